/* hdl/counting_semaphore_fifo_waitq_assert.svh */
// Assertion macros shared by the semaphore block.
`ifndef COUNTING_SEMAPHORE_FIFO_WAITQ_ASSERT_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITQ_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CSFW_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("semaphore assertion failed");

// Next-cycle implication, checked outside reset.
`define CSFW_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("semaphore assertion failed");

`endif

/* hdl/csfw_pkg.sv */
package csfw_pkg;

  localparam int MAX_WAITERS_DEF    = 16;
  localparam int THREAD_ID_BITS_DEF = 6;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int INIT_W   = 15;
  localparam int COUNT_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'h7fff;
  localparam logic [COUNT_W-1:0] COUNT_MIN = 16'h8000;

  localparam logic [KIND_W-1:0] KIND_WAIT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SIGNAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BLOCKED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_ERROR   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

endpackage

/* hdl/csfw_queue_ram.sv */
module csfw_queue_ram #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 6,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hdl/csfw_ctrl.sv */
`include "counting_semaphore_fifo_waitq_assert.svh"

module csfw_ctrl #(
  parameter int MAX_WAITERS    = 16,
  parameter int THREAD_ID_BITS = 6,
  parameter int IDX_W          = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [csfw_pkg::KIND_W-1:0]       in_kind,
  input  logic                              in_running_valid,
  input  logic [THREAD_ID_BITS-1:0]         in_running_thread,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [csfw_pkg::INIT_W-1:0]       cfg_data,
  output logic                              out_valid,
  output logic [csfw_pkg::STATUS_W-1:0]     out_status,
  output logic                              out_released_valid,
  output logic [THREAD_ID_BITS-1:0]         out_released_thread,
  output logic                              out_last,
  output logic                              wr_en,
  output logic [IDX_W-1:0]                  wr_addr,
  output logic [THREAD_ID_BITS-1:0]         wr_data,
  output logic                              rd_en,
  output logic [IDX_W-1:0]                  rd_addr,
  input  logic [THREAD_ID_BITS-1:0]         rd_data
);

  import csfw_pkg::*;

  localparam int FILL_W = $clog2(MAX_WAITERS + 1);

  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]     head_r, head_nxt;
  logic [IDX_W-1:0]     tail_r, tail_nxt;
  logic [FILL_W-1:0]    fill_r, fill_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  status_r, status_nxt;
  logic                 rel_valid_r, rel_valid_nxt;
  logic                 last_r, last_nxt;

  logic [COUNT_W-1:0]   count_dec;
  logic [COUNT_W-1:0]   count_inc;
  logic                 accept;
  logic                 queue_full;
  logic                 final_entry;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
    ring_next = (idx == IDX_W'(MAX_WAITERS - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign busy        = (state_r == ST_DRAIN);
  assign cfg_ready   = ~busy;
  assign accept      = start & ~busy;
  assign queue_full  = (fill_r == FILL_W'(MAX_WAITERS));
  assign final_entry = (fill_r == FILL_W'(1));

  // Saturate at the count limits.
  assign count_dec = (count_r == COUNT_MIN) ? count_r : count_r - 1'b1;
  assign count_inc = (count_r == COUNT_MAX) ? count_r : count_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      status_r    <= STATUS_OK;
      rel_valid_r <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
      rel_valid_r <= rel_valid_nxt;
      last_r      <= last_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    out_valid_nxt = 1'b0;
    status_nxt    = STATUS_OK;
    rel_valid_nxt = 1'b0;
    last_nxt      = 1'b1;
    wr_en         = 1'b0;
    wr_addr       = tail_r;
    wr_data       = in_running_thread;
    rd_en         = 1'b0;
    rd_addr       = head_r;

    case (state_r)
      ST_IDLE: begin
        if (cfg_valid) begin
          count_nxt = {1'b0, cfg_data};
        end
        if (accept) begin
          out_valid_nxt = 1'b1;
          case (in_kind)
            KIND_WAIT: begin
              count_nxt = count_dec;
              if (count_dec[COUNT_W-1]) begin
                if (!in_running_valid) begin
                  status_nxt = STATUS_ERROR;
                end else if (queue_full) begin
                  status_nxt = STATUS_FULL;
                end else begin
                  wr_en      = 1'b1;
                  tail_nxt   = ring_next(tail_r);
                  fill_nxt   = fill_r + 1'b1;
                  status_nxt = STATUS_BLOCKED;
                end
              end
            end
            KIND_SIGNAL: begin
              count_nxt = count_inc;
              if (count_inc[COUNT_W-1] || count_inc == '0) begin
                if (fill_r == '0) begin
                  status_nxt = STATUS_ERROR;
                end else begin
                  rd_en         = 1'b1;
                  head_nxt      = ring_next(head_r);
                  fill_nxt      = fill_r - 1'b1;
                  rel_valid_nxt = 1'b1;
                end
              end
            end
            KIND_CLOSE: begin
              if (fill_r != '0) begin
                rd_en         = 1'b1;
                head_nxt      = ring_next(head_r);
                fill_nxt      = fill_r - 1'b1;
                rel_valid_nxt = 1'b1;
                last_nxt      = final_entry;
                if (!final_entry) begin
                  state_nxt = ST_DRAIN;
                end
              end
            end
            default: begin
              status_nxt = STATUS_ERROR;
            end
          endcase
        end
      end
      ST_DRAIN: begin
        // Release one waiter per cycle until the queue is empty.
        out_valid_nxt = 1'b1;
        rd_en         = 1'b1;
        head_nxt      = ring_next(head_r);
        fill_nxt      = fill_r - 1'b1;
        rel_valid_nxt = 1'b1;
        last_nxt      = final_entry;
        if (final_entry) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_released_valid  = rel_valid_r;
  assign out_released_thread = rel_valid_r ? rd_data : '0;
  assign out_last            = last_r;

  `CSFW_ASSERT_NOW(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FILL_W'(MAX_WAITERS))
  `CSFW_ASSERT_NOW(a_drain_nonempty, clk, rst_n, state_r == ST_DRAIN, fill_r != '0)
  `CSFW_ASSERT_NOW(a_more_to_come, clk, rst_n, out_valid_r && !last_r, state_r == ST_DRAIN)
  `CSFW_ASSERT_NOW(a_release_strobed, clk, rst_n, rel_valid_r, out_valid_r)
  `CSFW_ASSERT_NEXT(a_drain_streams, clk, rst_n, state_r == ST_DRAIN,
                    out_valid_r && rel_valid_r)

endmodule

/* hdl/counting_semaphore_fifo_waitq.sv */
// Counting semaphore with a FIFO wait queue held in one synchronous memory.
// Wait and signal never raise busy; their result shows on the out_ ports
// for one cycle, in the cycle after start is taken. A close releases its
// queued waiters in order through the one memory read port, one waiter
// per cycle, with busy high while the queue drains; its results stream
// on consecutive cycles, out_last marking the final one. out_valid is a
// strobe: the receiver cannot stall, so every result must be captured in
// the cycle it is shown. Write initial_count through cfg_ only while no
// transaction is outstanding; the write also reloads the count, leaving
// the queue as it is.
module counting_semaphore_fifo_waitq #(
  parameter int MAX_WAITERS    = csfw_pkg::MAX_WAITERS_DEF,
  parameter int THREAD_ID_BITS = csfw_pkg::THREAD_ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [csfw_pkg::KIND_W-1:0]   in_kind,
  input  logic                          in_running_valid,
  input  logic [THREAD_ID_BITS-1:0]     in_running_thread,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [csfw_pkg::INIT_W-1:0]   cfg_data,
  output logic                          out_valid,
  output logic [csfw_pkg::STATUS_W-1:0] out_status,
  output logic                          out_released_valid,
  output logic [THREAD_ID_BITS-1:0]     out_released_thread,
  output logic                          out_last
);

  import csfw_pkg::*;

  localparam int IDX_W = $clog2(MAX_WAITERS);

  logic                      wr_en;
  logic [IDX_W-1:0]          wr_addr;
  logic [THREAD_ID_BITS-1:0] wr_data;
  logic                      rd_en;
  logic [IDX_W-1:0]          rd_addr;
  logic [THREAD_ID_BITS-1:0] rd_data;

  csfw_ctrl #(
    .MAX_WAITERS    (MAX_WAITERS),
    .THREAD_ID_BITS (THREAD_ID_BITS),
    .IDX_W          (IDX_W)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_running_valid    (in_running_valid),
    .in_running_thread   (in_running_thread),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_released_valid  (out_released_valid),
    .out_released_thread (out_released_thread),
    .out_last            (out_last),
    .wr_en               (wr_en),
    .wr_addr             (wr_addr),
    .wr_data             (wr_data),
    .rd_en               (rd_en),
    .rd_addr             (rd_addr),
    .rd_data             (rd_data)
  );

  csfw_queue_ram #(
    .DEPTH  (MAX_WAITERS),
    .DATA_W (THREAD_ID_BITS),
    .ADDR_W (IDX_W)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

/* bench/tb_counting_semaphore_fifo_waitq.sv */
`timescale 1ns / 1ps

module tb_counting_semaphore_fifo_waitq;
  import csfw_pkg::*;

  localparam int QDEPTH = MAX_WAITERS_DEF;
  localparam int TID_W = THREAD_ID_BITS_DEF;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int TAIL_CYCLES = QDEPTH + 4;
  localparam int QUIET_LIMIT = 400;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic freed_valid;
    logic [TID_W-1:0] freed_thread;
    logic is_last;
  } outcome_t;

  class sem_tracker;
    logic signed [COUNT_W-1:0] level;
    logic [TID_W-1:0] ring [QDEPTH];
    int unsigned head;
    int unsigned tail;
    int unsigned fill;
    outcome_t pending[$];
    int unsigned errors;

    function new();
      level = '0;
      head = 0;
      tail = 0;
      fill = 0;
      errors = 0;
    endfunction

    // A register write reloads the count; the queue keeps its waiters.
    function void load_count(logic [INIT_W-1:0] value);
      level = {1'b0, value};
    endfunction

    function void push(logic [STATUS_W-1:0] st, logic fv, logic [TID_W-1:0] id, logic lst);
      outcome_t o;
      o.status = st;
      o.freed_valid = fv;
      o.freed_thread = fv ? id : '0;
      o.is_last = lst;
      pending.push_back(o);
    endfunction

    function logic [TID_W-1:0] dequeue_oldest();
      logic [TID_W-1:0] id;
      id = ring[head];
      head = (head + 1) % QDEPTH;
      fill--;
      return id;
    endfunction

    function void note_request(logic [KIND_W-1:0] kind, logic rv, logic [TID_W-1:0] thread);
      logic [TID_W-1:0] id;
      case (kind)
        KIND_WAIT: begin
          if (level != $signed(COUNT_MIN)) level = level - 1'b1;
          if (level < 0) begin
            if (!rv) begin
              push(STATUS_ERROR, 1'b0, '0, 1'b1);
            end else if (fill >= QDEPTH) begin
              push(STATUS_FULL, 1'b0, '0, 1'b1);
            end else begin
              ring[tail] = thread;
              tail = (tail + 1) % QDEPTH;
              fill++;
              push(STATUS_BLOCKED, 1'b0, '0, 1'b1);
            end
          end else begin
            push(STATUS_OK, 1'b0, '0, 1'b1);
          end
        end
        KIND_SIGNAL: begin
          if (level != $signed(COUNT_MAX)) level = level + 1'b1;
          if (level <= 0) begin
            if (fill == 0) begin
              push(STATUS_ERROR, 1'b0, '0, 1'b1);
            end else begin
              id = dequeue_oldest();
              push(STATUS_OK, 1'b1, id, 1'b1);
            end
          end else begin
            push(STATUS_OK, 1'b0, '0, 1'b1);
          end
        end
        KIND_CLOSE: begin
          if (fill == 0) begin
            push(STATUS_OK, 1'b0, '0, 1'b1);
          end else begin
            // release every waiter in queue order; the count stays put
            while (fill > 0) begin
              id = dequeue_oldest();
              push(STATUS_OK, 1'b1, id, fill == 0);
            end
          end
        end
        default: begin
          push(STATUS_ERROR, 1'b0, '0, 1'b1);
        end
      endcase
    endfunction

    function void check_release(outcome_t got);
      outcome_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: unexpected transaction: status %0d freed %0b/%0d last %0b",
                   $realtime, got.status, got.freed_valid, got.freed_thread, got.is_last);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display({"%0t: mismatch: expected status %0d freed %0b/%0d last %0b, ",
                    "got status %0d freed %0b/%0d last %0b"},
                   $realtime, want.status, want.freed_valid, want.freed_thread,
                   want.is_last, got.status, got.freed_valid, got.freed_thread,
                   got.is_last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [KIND_W-1:0] in_kind = '0;
  logic in_running_valid = 1'b0;
  logic [TID_W-1:0] in_running_thread = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [INIT_W-1:0] cfg_data = '0;
  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic out_released_valid;
  logic [TID_W-1:0] out_released_thread;
  logic out_last;

  sem_tracker tracker = new();
  int unsigned quiet_cycles = 0;

  counting_semaphore_fifo_waitq dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_running_valid    (in_running_valid),
    .in_running_thread   (in_running_thread),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_released_valid  (out_released_valid),
    .out_released_thread (out_released_thread),
    .out_last            (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      tracker.check_release({out_status, out_released_valid, out_released_thread, out_last});
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_counting_semaphore_fifo_waitq: FAIL");
      $finish;
    end
  end

  // Hold start high until a transaction is taken; start stays high for the next call.
  task automatic issue(logic [KIND_W-1:0] kind, logic rv, logic [TID_W-1:0] thread, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_kind <= kind;
    in_running_valid <= rv;
    in_running_thread <= thread;
    @(posedge clk);
    while (busy) @(posedge clk);
    tracker.note_request(kind, rv, thread);
  endtask

  task automatic hold_off();
    start <= 1'b0;
    @(posedge clk);
    while (tracker.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_init(logic [INIT_W-1:0] value);
    hold_off();
    repeat (TAIL_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tracker.load_count(value);
  endtask

  function automatic int pick_gap(int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) return $urandom_range(1, 19);
    return 0;
  endfunction

  task automatic random_item(int idle_pct);
    int r;
    int g;
    r = $urandom_range(0, 99);
    g = pick_gap(idle_pct);
    if (r < 46)
      issue(KIND_WAIT, 1'b1, TID_W'($urandom_range(0, 63)), g);
    else if (r < 84)
      issue(KIND_SIGNAL, 1'($urandom_range(0, 1)), TID_W'($urandom_range(0, 63)), g);
    else if (r < 91)
      issue(KIND_CLOSE, 1'($urandom_range(0, 1)), TID_W'($urandom_range(0, 63)), g);
    else if (r < 96)
      issue(KIND_WAIT, 1'b0, TID_W'($urandom_range(0, 63)), g);
    else
      issue(KIND_UNUSED, 1'($urandom_range(0, 1)), TID_W'($urandom_range(0, 63)), g);
  endtask

  initial begin
    logic [INIT_W-1:0] settings [5];
    int idle_pct;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_init('0);
    issue(KIND_CLOSE, 1'b0, '0, 0);      // nothing queued
    issue(KIND_UNUSED, 1'b1, 6'd63, 0);
    issue(KIND_WAIT, 1'b0, 6'd63, 0);    // no running thread
    issue(KIND_SIGNAL, 1'b0, '0, 0);     // empty queue at zero
    issue(KIND_WAIT, 1'b1, 6'd63, 0);
    issue(KIND_WAIT, 1'b1, 6'd0, 3);
    issue(KIND_WAIT, 1'b1, 6'd42, 0);
    issue(KIND_WAIT, 1'b1, 6'd21, 0);
    for (int i = 4; i < QDEPTH; i++)
      issue(KIND_WAIT, 1'b1, TID_W'($urandom_range(0, 63)), pick_gap(20));
    issue(KIND_WAIT, 1'b1, 6'd5, 0);     // queue full
    issue(KIND_SIGNAL, 1'b1, '0, 0);
    issue(KIND_WAIT, 1'b1, 6'd33, 0);
    issue(KIND_CLOSE, 1'b1, 6'd63, 2);   // longest drain

    // Top of the count range.
    write_init(15'h7fff);
    issue(KIND_SIGNAL, 1'b0, '0, 0);
    issue(KIND_WAIT, 1'b1, 6'd17, 0);

    // Drive the count below zero with nobody queued.
    write_init('0);
    for (int i = 0; i < 6; i++)
      issue(KIND_WAIT, 1'b0, TID_W'($urandom_range(0, 63)), 0);
    issue(KIND_SIGNAL, 1'b0, '0, 0);
    issue(KIND_WAIT, 1'b0, '0, 0);
    issue(KIND_WAIT, 1'b0, '0, 0);

    settings[0] = 15'd2;
    settings[1] = 15'd0;
    settings[2] = 15'h7fff;
    settings[3] = INIT_W'($urandom_range(0, 3));
    settings[4] = INIT_W'($urandom_range(0, 2));
    for (int p = 0; p < 5; p++) begin
      write_init(settings[p]);
      idle_pct = (p == 4) ? 0 : (p == 1 ? 5 : 30);
      for (int i = 0; i < 46; i++) begin
        random_item(idle_pct);
        if (p != 4 && $urandom_range(0, 39) == 0) hold_off();
      end
    end

    hold_off();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending.size() == 0)
      $display("tb_counting_semaphore_fifo_waitq: PASS");
    else
      $display("tb_counting_semaphore_fifo_waitq: FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/csfw_pkg.sv
hdl/csfw_queue_ram.sv
hdl/csfw_ctrl.sv
hdl/counting_semaphore_fifo_waitq.sv
bench/tb_counting_semaphore_fifo_waitq.sv
